// File: hdl/mdgis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdgis_pkg
// Shared widths, codes and hand-off types of the min-degree greedy
// independent set unit.
// ----------------------------------------------------------------------------
package mdgis_pkg;

   localparam int MAX_NODES  = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int ROW_W      = 64;
   localparam int DEG_W      = 7;
   localparam int LFSR_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIE_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LFSR_SEED  = 2'd2;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [CNT_W-1:0]  divisor;
      logic [LFSR_W-1:0] dividend;
   } mod_req_type;

   typedef struct packed {
      logic             valid;
      logic             win;
      logic [IDX_W-1:0] idx;
   } mod_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [DEG_W-1:0] degree;
   } pop_rsp_type;

endpackage

// File: hdl/mdgis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdgis_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mdgis_req_if;
   import mdgis_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [IDX_W-1:0] node_index;
   logic [ROW_W-1:0] row_bits;

   modport source (output valid, output op, output node_index, output row_bits, input ready);
   modport sink (input valid, input op, input node_index, input row_bits, output ready);
endinterface

interface mdgis_rsp_if;
   import mdgis_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] vertex;
   logic [CNT_W-1:0] set_size;
   logic             last;

   modport source (output valid, output vertex, output set_size, output last, input ready);
   modport sink (input valid, input vertex, input set_size, input last, output ready);
endinterface

// File: hdl/min_degree_greedy_independent_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_degree_greedy_independent_set_unit
// Greedy maximal independent set by least static degree over stored rows.
// ----------------------------------------------------------------------------
// A load beat writes one adjacency row and, through the popcount pipeline,
// its degree; the unit takes no new beat until that degree is stored. A run
// beat emits one response beat per chosen vertex. Each pick scans the degree
// memory over the n vertices in use, drains the read and remainder pipeline,
// then sweeps the row memory to drop neighbors and then emits.
// Both memories have one read port with a registered read; the response
// register lets the next pick proceed while a beat waits to be taken.
// ----------------------------------------------------------------------------
module min_degree_greedy_independent_set_unit (
   input  logic                             clock,
   input  logic                             reset,
   mdgis_req_if.sink                        req_chan,
   mdgis_rsp_if.source                      rsp_chan,
   input  logic                             csr_we,
   input  logic [mdgis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mdgis_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mdgis_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REMOVE,
      ST_REMOVE_WAIT,
      ST_EMIT
   } state_type;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] r;
      r = s >> 1;
      if (s[0]) begin
         r = r ^ LFSR_TAPS;
      end
      return r;
   endfunction

   // configuration
   logic [CNT_W-1:0]  node_count_ff;
   logic              tie_mode_ff;
   logic [LFSR_W-1:0] lfsr_seed_ff;

   // memories
   logic [ROW_W-1:0] row_mem [MAX_NODES];
   logic [DEG_W-1:0] deg_mem [MAX_NODES];
   logic [ROW_W-1:0] row_rd_ff;
   logic [DEG_W-1:0] deg_rd_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  rd_q_idx_ff, rd_q_idx_in;
   logic [IDX_W-1:0]  last_idx_ff, last_idx_in;
   logic              deg_v_ff, deg_v_in;
   logic              row_v_ff, row_v_in;
   logic [ROW_W-1:0]  cand_ff, cand_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic              have_ff, have_in;
   logic [DEG_W-1:0]  mindeg_ff, mindeg_in;
   logic [CNT_W-1:0]  ties_ff, ties_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic [CNT_W-1:0]  rsp_size_ff, rsp_size_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              load_fire;
   logic              emit_fire;
   logic [CNT_W-1:0]  n_eff;
   logic [ROW_W-1:0]  init_mask;
   logic [CNT_W-1:0]  tie_base;
   logic [LFSR_W-1:0] lfsr_next;

   logic        mod_push;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;
   logic        mod_busy;
   pop_rsp_type pop_rsp;
   logic        pop_busy;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign load_fire = req_fire && (req_chan.op == OP_LOAD);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign n_eff     = (node_count_ff > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_ff;
   assign lfsr_next = lfsr_step(lfsr_ff);

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         init_mask[i] = (CNT_W'(i) < n_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(MAX_NODES);
         tie_mode_ff   <= 1'b1;
         lfsr_seed_ff  <= LFSR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_TIE_MODE:   tie_mode_ff   <= csr_wdata[0];
            CSR_LFSR_SEED:  lfsr_seed_ff  <= csr_wdata[LFSR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         row_mem[req_chan.node_index] <= req_chan.row_bits;
      end
      if (pop_rsp.valid) begin
         deg_mem[pop_rsp.idx] <= pop_rsp.degree;
      end
      row_rd_ff <= row_mem[rd_idx_ff];
      deg_rd_ff <= deg_mem[rd_idx_ff];
   end

   mdgis_popcnt u_popcnt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (load_fire),
      .in_idx   (req_chan.node_index),
      .in_row   (req_chan.row_bits),
      .out      (pop_rsp),
      .busy     (pop_busy)
   );

   mdgis_mod_pipe u_mod_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mod_push),
      .in_req   (mod_req),
      .out      (mod_rsp),
      .busy     (mod_busy)
   );

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      rd_q_idx_in   = rd_idx_ff;
      last_idx_in   = last_idx_ff;
      deg_v_in      = 1'b0;
      row_v_in      = 1'b0;
      cand_in       = cand_ff;
      count_in      = count_ff;
      pick_in       = pick_ff;
      have_in       = have_ff;
      mindeg_in     = mindeg_ff;
      ties_in       = ties_ff;
      lfsr_in       = lfsr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;
      mod_push      = 1'b0;
      mod_req       = '{idx: rd_q_idx_ff, divisor: CNT_W'(1), dividend: lfsr_ff};
      tie_base      = '0;

      // degree compare stage
      if (deg_v_ff && cand_ff[rd_q_idx_ff]) begin
         if (!have_ff) begin
            have_in   = 1'b1;
            mindeg_in = deg_rd_ff;
            ties_in   = CNT_W'(1);
            mod_push  = 1'b1;
         end else if (deg_rd_ff <= mindeg_ff) begin
            if (tie_mode_ff) begin
               tie_base         = (deg_rd_ff < mindeg_ff) ? '0 : ties_ff;
               lfsr_in          = lfsr_next;
               mod_push         = 1'b1;
               mod_req.divisor  = tie_base + CNT_W'(1);
               mod_req.dividend = lfsr_next;
               ties_in          = tie_base + CNT_W'(1);
               mindeg_in        = deg_rd_ff;
            end else if (deg_rd_ff < mindeg_ff) begin
               mod_push  = 1'b1;
               mindeg_in = deg_rd_ff;
            end
         end
      end

      if (mod_rsp.valid && mod_rsp.win) begin
         pick_in = mod_rsp.idx;
      end

      // neighbor drop stage
      if (row_v_ff && row_rd_ff[pick_ff]) begin
         cand_in[rd_q_idx_ff] = 1'b0;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.op == OP_RUN) && (n_eff != '0)) begin
               cand_in     = init_mask;
               lfsr_in     = (lfsr_seed_ff == '0) ? LFSR_W'(1) : lfsr_seed_ff;
               count_in    = '0;
               last_idx_in = IDX_W'(n_eff - CNT_W'(1));
               rd_idx_in   = '0;
               have_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            deg_v_in = 1'b1;
            if (rd_idx_ff == last_idx_ff) begin
               rd_idx_in = '0;
               state_in  = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!deg_v_ff && !mod_busy) begin
               cand_in[pick_ff] = 1'b0;
               state_in         = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            row_v_in = 1'b1;
            if (rd_idx_ff == last_idx_ff) begin
               rd_idx_in = '0;
               state_in  = ST_REMOVE_WAIT;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_REMOVE_WAIT: begin
            if (!row_v_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pick_ff;
               rsp_size_in   = count_ff + CNT_W'(1);
               rsp_last_in   = (cand_ff == '0);
               count_in      = count_ff + CNT_W'(1);
               have_in       = 1'b0;
               rd_idx_in     = '0;
               state_in      = (cand_ff == '0) ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         deg_v_ff     <= 1'b0;
         row_v_ff     <= 1'b0;
         cand_ff      <= '0;
         have_ff      <= 1'b0;
         lfsr_ff      <= LFSR_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         deg_v_ff     <= deg_v_in;
         row_v_ff     <= row_v_in;
         cand_ff      <= cand_in;
         have_ff      <= have_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      rd_q_idx_ff   <= rd_q_idx_in;
      last_idx_ff   <= last_idx_in;
      count_ff      <= count_in;
      pick_ff       <= pick_in;
      mindeg_ff     <= mindeg_in;
      ties_ff       <= ties_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready    = (state_ff == ST_IDLE) && !pop_busy;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.vertex   = rsp_vertex_ff;
   assign rsp_chan.set_size = rsp_size_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // picked vertex has left the candidates before it is emitted
   a_pick_removed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !cand_ff[pick_ff])
      else $error("picked vertex still a candidate at emit");

   // no scan or remainder work outstanding while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mod_busy && !deg_v_ff && !row_v_ff))
      else $error("pipeline active while idle");

   // emptying the candidates ends the run with a last beat
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (cand_ff == '0)) |=>
         ((state_ff == ST_IDLE) && rsp_chan.valid && rsp_chan.last))
      else $error("run did not end on last beat");

endmodule

// File: hdl/mdgis_popcnt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdgis_popcnt
// Two-stage degree counter: popcount of a row with its self bit masked.
// ----------------------------------------------------------------------------
module mdgis_popcnt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [mdgis_pkg::IDX_W-1:0] in_idx,
   input  logic [mdgis_pkg::ROW_W-1:0] in_row,
   output mdgis_pkg::pop_rsp_type    out,
   output logic                      busy
);
   import mdgis_pkg::*;

   localparam int NBYTES = ROW_W / 8;

   logic                     s1_valid_ff;
   logic [IDX_W-1:0]         s1_idx_ff;
   logic [NBYTES-1:0][3:0]   s1_cnt_ff;
   logic [NBYTES-1:0][3:0]   s1_cnt_in;
   logic                     s2_valid_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic [DEG_W-1:0]         s2_deg_ff;
   logic [DEG_W-1:0]         s2_deg_in;
   logic [ROW_W-1:0]         masked;

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         masked[i] = in_row[i] && (IDX_W'(i) != in_idx);
      end
      for (int b = 0; b < NBYTES; b++) begin
         s1_cnt_in[b] = '0;
         for (int j = 0; j < 8; j++) begin
            s1_cnt_in[b] = s1_cnt_in[b] + {3'd0, masked[b*8+j]};
         end
      end
   end

   always_comb begin
      s2_deg_in = '0;
      for (int b = 0; b < NBYTES; b++) begin
         s2_deg_in = s2_deg_in + DEG_W'(s1_cnt_ff[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_idx_ff <= in_idx;
      s1_cnt_ff <= s1_cnt_in;
      s2_idx_ff <= s1_idx_ff;
      s2_deg_ff <= s2_deg_in;
   end

   assign out.valid  = s2_valid_ff;
   assign out.idx    = s2_idx_ff;
   assign out.degree = s2_deg_ff;
   assign busy       = s1_valid_ff || s2_valid_ff;

endmodule

// File: hdl/mdgis_mod_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdgis_mod_pipe
// Two-stage restoring remainder of the tie LFSR by the tie count; a zero
// remainder marks the candidate as the new pick.
// ----------------------------------------------------------------------------
module mdgis_mod_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  mdgis_pkg::mod_req_type in_req,
   output mdgis_pkg::mod_rsp_type out,
   output logic                   busy
);
   import mdgis_pkg::*;

   localparam int HALF = LFSR_W / 2;

   logic                 s1_valid_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [CNT_W-1:0]     s1_div_ff;
   logic [HALF-1:0]      s1_low_ff;
   logic [CNT_W-1:0]     s1_rem_ff;
   logic [CNT_W-1:0]     s1_rem_in;
   logic                 s2_valid_ff;
   logic [IDX_W-1:0]     s2_idx_ff;
   logic                 s2_win_ff;
   logic [CNT_W-1:0]     s2_rem;
   logic [CNT_W:0]       part_a;
   logic [CNT_W:0]       part_b;

   // upper half of the dividend
   always_comb begin
      s1_rem_in = '0;
      part_a    = '0;
      for (int k = LFSR_W - 1; k >= HALF; k--) begin
         part_a = {s1_rem_in, in_req.dividend[k]};
         if (part_a >= {1'b0, in_req.divisor}) begin
            part_a = part_a - {1'b0, in_req.divisor};
         end
         s1_rem_in = part_a[CNT_W-1:0];
      end
   end

   // lower half
   always_comb begin
      s2_rem = s1_rem_ff;
      part_b = '0;
      for (int k = HALF - 1; k >= 0; k--) begin
         part_b = {s2_rem, s1_low_ff[k]};
         if (part_b >= {1'b0, s1_div_ff}) begin
            part_b = part_b - {1'b0, s1_div_ff};
         end
         s2_rem = part_b[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_idx_ff <= in_req.idx;
      s1_div_ff <= in_req.divisor;
      s1_low_ff <= in_req.dividend[HALF-1:0];
      s1_rem_ff <= s1_rem_in;
      s2_idx_ff <= s1_idx_ff;
      s2_win_ff <= (s2_rem == '0);
   end

   assign out.valid = s2_valid_ff;
   assign out.win   = s2_win_ff;
   assign out.idx   = s2_idx_ff;
   assign busy      = s1_valid_ff || s2_valid_ff;

endmodule
